// File: hdl/salc_pkg.sv
package salc_pkg;

    localparam int CFG_DATA_W  = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CNT_W       = 32;
    localparam int STAMP_W     = 32;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd2;

    typedef enum logic [1:0] {
        CMD_IFETCH = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_STORE  = 2'd2,
        CMD_MODIFY = 2'd3
    } cmd_t;

    typedef enum logic {
        BK_READ = 1'b0,
        BK_EVAL = 1'b1
    } back_state_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

// File: hdl/salc_front.sv
module salc_front
    import salc_pkg::*;
#(
    parameter int MAX_SET_BITS = 8,
    parameter int ADDR_WIDTH   = 64,
    localparam int SET_W       = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
    localparam int ENTRY_W     = SET_W + ADDR_WIDTH + STAMP_W + 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic [63:0]        address,
    input  logic [3:0]         set_bits,
    input  logic [5:0]         block_bits,
    input  q_status_t          q_status,
    output logic               push,
    output logic [ENTRY_W-1:0] push_data
);

    typedef struct packed {
        logic [SET_W-1:0]      set_idx;
        logic [ADDR_WIDTH-1:0] tag;
        logic [STAMP_W-1:0]    stamp;
        logic                  modify;
    } entry_t;

    logic [STAMP_W-1:0]    time_reg;
    logic [STAMP_W-1:0]    time_next;
    logic                  accept;
    logic [4:0]            sb_eff;
    logic [6:0]            tag_shift;
    logic [ADDR_WIDTH-1:0] addr_a;
    logic [ADDR_WIDTH-1:0] shifted;
    logic [ADDR_WIDTH-1:0] set_mask;
    logic [ADDR_WIDTH-1:0] set_full;
    entry_t                entry;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !in_stall;
    assign push     = accept && (cmd_t'(cmd) != CMD_IFETCH);

    always_comb
    begin
        if (int'(set_bits) > MAX_SET_BITS)
        begin
            sb_eff = 5'(MAX_SET_BITS);
        end
        else
        begin
            sb_eff = {1'b0, set_bits};
        end
        tag_shift = 7'(sb_eff) + 7'(block_bits);
        addr_a    = address[ADDR_WIDTH-1:0];
        shifted   = addr_a >> block_bits;
        set_mask  = ~({ADDR_WIDTH{1'b1}} << sb_eff);
        set_full  = shifted & set_mask;

        entry.set_idx = set_full[SET_W-1:0];
        // shifts at or past the address width leave a zero tag
        entry.tag     = addr_a >> tag_shift;
        entry.stamp   = time_reg;
        entry.modify  = (cmd_t'(cmd) == CMD_MODIFY);
    end

    assign push_data = entry;

    // advance time on every request, fetches included
    assign time_next = accept ? time_reg + STAMP_W'(1) : time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= '0;
        end
        else
        begin
            time_reg <= time_next;
        end
    end

endmodule

// File: hdl/salc_queue.sv
module salc_queue
    import salc_pkg::*;
#(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_QW = $clog2(DEPTH + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] head_data,
    output q_status_t         q_status
);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_QW-1:0] count_reg;
    logic [CNT_QW-1:0] count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (int'(p) == DEPTH - 1)
        begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    assign head_data      = slot_reg[rd_ptr_reg];
    assign q_status.empty = (count_reg == '0);
    assign q_status.full  = (int'(count_reg) == DEPTH);

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_QW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_QW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hdl/salc_back.sv
module salc_back
    import salc_pkg::*;
#(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_WIDTH   = 64,
    localparam int SET_W       = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
    localparam int ENTRY_W     = SET_W + ADDR_WIDTH + STAMP_W + 1,
    localparam int ROWS        = 2 ** MAX_SET_BITS,
    localparam int WAY_W       = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
    localparam int NW_W        = $clog2(MAX_WAYS + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [3:0]         ways,
    input  q_status_t          q_status,
    input  logic [ENTRY_W-1:0] head_data,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               hit,
    output logic               miss,
    output logic               eviction,
    output logic               last,
    output logic [CNT_W-1:0]   hit_total,
    output logic [CNT_W-1:0]   miss_total,
    output logic [CNT_W-1:0]   eviction_total
);

    typedef struct packed {
        logic [SET_W-1:0]      set_idx;
        logic [ADDR_WIDTH-1:0] tag;
        logic [STAMP_W-1:0]    stamp;
        logic                  modify;
    } entry_t;

    typedef struct packed {
        logic [MAX_WAYS-1:0]                 valid;
        logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag;
        logic [MAX_WAYS-1:0][STAMP_W-1:0]    stamp;
    } row_t;

    row_t                mem [ROWS];
    row_t                rd_row_reg;
    logic                row_ok_reg;
    logic [ROWS-1:0]     row_written_reg;

    back_state_t         state_reg;
    back_state_t         state_next;
    logic                second_reg;
    logic                second_next;

    logic                out_valid_reg;
    logic                hit_reg;
    logic                evict_reg;
    logic                last_reg;
    logic [CNT_W-1:0]    hits_reg;
    logic [CNT_W-1:0]    misses_reg;
    logic [CNT_W-1:0]    evicts_reg;

    entry_t              head;
    row_t                cur;
    row_t                wr_row;
    logic                rd_en;
    logic                wr_en;
    logic                load_out;
    logic                out_free;
    logic                is_last;
    logic [NW_W-1:0]     nw;
    logic [MAX_WAYS-1:0] in_use;
    logic [MAX_WAYS-1:0] is_min;
    logic                hit_found;
    logic [WAY_W-1:0]    hit_way;
    logic                empty_found;
    logic [WAY_W-1:0]    empty_way;
    logic [WAY_W-1:0]    lru_way;
    logic [WAY_W-1:0]    victim;

    assign head = entry_t'(head_data);

    // an unwritten row reads as all lines invalid
    assign cur = row_ok_reg ? rd_row_reg : '0;

    always_comb
    begin
        if (ways == '0)
        begin
            nw = NW_W'(1);
        end
        else if (int'(ways) > MAX_WAYS)
        begin
            nw = NW_W'(MAX_WAYS);
        end
        else
        begin
            nw = NW_W'(ways);
        end
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            in_use[i] = (i < int'(nw));
        end
    end

    // lowest matching way wins the hit, highest free way takes the fill
    always_comb
    begin
        hit_found   = 1'b0;
        hit_way     = '0;
        empty_found = 1'b0;
        empty_way   = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--)
        begin
            if (in_use[i] && cur.valid[i] && (cur.tag[i] == head.tag))
            begin
                hit_found = 1'b1;
                hit_way   = WAY_W'(i);
            end
        end
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (in_use[i] && !cur.valid[i])
            begin
                empty_found = 1'b1;
                empty_way   = WAY_W'(i);
            end
        end
    end

    // a way is the victim if no earlier way is <= it and no later way is below it
    always_comb
    begin
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            is_min[i] = in_use[i];
            for (int j = 0; j < MAX_WAYS; j++)
            begin
                if (in_use[j] && (j < i) && !(cur.stamp[i] < cur.stamp[j]))
                begin
                    is_min[i] = 1'b0;
                end
                if (in_use[j] && (j > i) && (cur.stamp[j] < cur.stamp[i]))
                begin
                    is_min[i] = 1'b0;
                end
            end
        end
        lru_way = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--)
        begin
            if (is_min[i])
            begin
                lru_way = WAY_W'(i);
            end
        end
    end

    always_comb
    begin
        victim = empty_found ? empty_way : lru_way;
        wr_row = cur;
        if (hit_found)
        begin
            wr_row.stamp[hit_way] = head.stamp;
        end
        else
        begin
            wr_row.valid[victim] = 1'b1;
            wr_row.tag[victim]   = head.tag;
            wr_row.stamp[victim] = head.stamp;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign is_last  = !(head.modify && !second_reg);

    always_comb
    begin
        state_next  = state_reg;
        second_next = second_reg;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        pop         = 1'b0;
        load_out    = 1'b0;
        case (state_reg)
            BK_READ:
            begin
                if (!q_status.empty)
                begin
                    rd_en      = 1'b1;
                    state_next = BK_EVAL;
                end
            end
            BK_EVAL:
            begin
                if (out_free)
                begin
                    wr_en      = 1'b1;
                    load_out   = 1'b1;
                    state_next = BK_READ;
                    if (is_last)
                    begin
                        second_next = 1'b0;
                        pop         = 1'b1;
                    end
                    else
                    begin
                        // modify: rerun the same request as a store
                        second_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = BK_READ;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_row_reg <= mem[head.set_idx];
        end
        if (wr_en)
        begin
            mem[head.set_idx] <= wr_row;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            hit_reg   <= hit_found;
            evict_reg <= !hit_found && !empty_found;
            last_reg  <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= BK_READ;
            second_reg      <= 1'b0;
            row_ok_reg      <= 1'b0;
            row_written_reg <= '0;
            out_valid_reg   <= 1'b0;
            hits_reg        <= '0;
            misses_reg      <= '0;
            evicts_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            second_reg <= second_next;
            if (rd_en)
            begin
                row_ok_reg <= row_written_reg[head.set_idx];
            end
            if (wr_en)
            begin
                row_written_reg[head.set_idx] <= 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                if (hit_found)
                begin
                    hits_reg <= hits_reg + CNT_W'(1);
                end
                else
                begin
                    misses_reg <= misses_reg + CNT_W'(1);
                    if (!empty_found)
                    begin
                        evicts_reg <= evicts_reg + CNT_W'(1);
                    end
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign hit            = hit_reg;
    assign miss           = !hit_reg;
    assign eviction       = evict_reg;
    assign last           = last_reg;
    assign hit_total      = hits_reg;
    assign miss_total     = misses_reg;
    assign eviction_total = evicts_reg;

endmodule

// File: hdl/set_assoc_lru_cache_sim.sv
// Tag-only set-associative cache with LRU replacement, driven by a trace of
// accesses. Requests are decoded and split into set and tag on entry and wait
// in a four-deep queue; instruction fetches only advance the time stamp and
// produce no result. For each load or store the back end reads the set row,
// then compares all ways, writes the row back and registers the result; a
// modify does this twice and yields two results, the second one flagged
// last. The single set memory is read and then written once per access, one
// access at a time. Results carry hit, miss and eviction flags and wrapping
// 32-bit running totals. No clearing pass is needed after reset: a per-set
// written flag makes untouched sets read as empty. Write set_bits, ways and
// block_bits only while no request is in flight.
module set_assoc_lru_cache_sim
    import salc_pkg::*;
#(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_WIDTH   = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            cmd,
    input  logic [63:0]           address,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  hit,
    output logic                  miss,
    output logic                  eviction,
    output logic                  last,
    output logic [CNT_W-1:0]      hit_total,
    output logic [CNT_W-1:0]      miss_total,
    output logic [CNT_W-1:0]      eviction_total
);

    localparam int SET_W   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int ENTRY_W = SET_W + ADDR_WIDTH + STAMP_W + 1;

    logic [3:0]         set_bits_reg;
    logic [3:0]         ways_reg;
    logic [5:0]         block_bits_reg;
    q_status_t          q_status;
    logic               push;
    logic               pop;
    logic [ENTRY_W-1:0] push_data;
    logic [ENTRY_W-1:0] head_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= 4'd4;
            ways_reg       <= 4'd1;
            block_bits_reg <= 6'd4;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SET_BITS:   set_bits_reg   <= cfg_data[3:0];
                REG_WAYS:       ways_reg       <= cfg_data[3:0];
                REG_BLOCK_BITS: block_bits_reg <= cfg_data[5:0];
                default:
                begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    salc_front #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .ADDR_WIDTH   (ADDR_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .address    (address),
        .set_bits   (set_bits_reg),
        .block_bits (block_bits_reg),
        .q_status   (q_status),
        .push       (push),
        .push_data  (push_data)
    );

    salc_queue #(
        .DATA_W (ENTRY_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .q_status  (q_status)
    );

    salc_back #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .ADDR_WIDTH   (ADDR_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .ways           (ways_reg),
        .q_status       (q_status),
        .head_data      (head_data),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hit            (hit),
        .miss           (miss),
        .eviction       (eviction),
        .last           (last),
        .hit_total      (hit_total),
        .miss_total     (miss_total),
        .eviction_total (eviction_total)
    );

`ifndef SYNTHESIS
    a_evict_is_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && eviction |-> miss)
        else $error("eviction reported on a hit");

    a_totals_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) ##1 out_valid |->
            (32'(hit_total + miss_total) ==
             32'($past(hit_total) + $past(miss_total) + 32'd1)))
        else $error("hit and miss totals did not advance by one per result");

    a_evict_total: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) ##1 (out_valid && !eviction) |->
            (eviction_total == $past(eviction_total)))
        else $error("eviction total moved without an eviction");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("queue popped while empty");
`endif

endmodule

// File: sim/cache_trace_checker.sv
module cache_trace_checker
    import salc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [1:0]            cmd,
    input  logic [63:0]           address,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic                  hit,
    input  logic                  miss,
    input  logic                  eviction,
    input  logic                  last,
    input  logic [CNT_W-1:0]      hit_total,
    input  logic [CNT_W-1:0]      miss_total,
    input  logic [CNT_W-1:0]      eviction_total,
    output int unsigned           mismatch_count,
    output int unsigned           results_due
);

    localparam int SET_BITS_CAP = 8;
    localparam int WAY_CAP      = 8;
    localparam int LINE_COUNT   = (1 << SET_BITS_CAP) * WAY_CAP;
    localparam int PRINT_CAP    = 30;

    typedef struct packed {
        logic             hit;
        logic             miss;
        logic             eviction;
        logic             last;
        logic [CNT_W-1:0] hit_total;
        logic [CNT_W-1:0] miss_total;
        logic [CNT_W-1:0] eviction_total;
    } access_result_t;

    access_result_t     pending_results[$];
    access_result_t     got;
    access_result_t     want;

    logic               line_valid [LINE_COUNT];
    logic [63:0]        line_tag   [LINE_COUNT];
    logic [STAMP_W-1:0] line_stamp [LINE_COUNT];
    logic [STAMP_W-1:0] time_now;
    logic [CNT_W-1:0]   hits_seen;
    logic [CNT_W-1:0]   misses_seen;
    logic [CNT_W-1:0]   evictions_seen;

    logic [3:0]         set_bits_r;
    logic [3:0]         ways_r;
    logic [5:0]         block_bits_r;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("checker: %0t: %s", $time, msg);
    endtask

    // Look up one access in the tag store and update the running totals.
    function automatic access_result_t predict_access(input logic [63:0] addr,
                                                      input logic is_last);
        int                 sb;
        int                 nw;
        int                 bb;
        int                 base;
        int                 empty_way;
        int                 victim;
        logic [63:0]        set_idx;
        logic [63:0]        tag;
        logic               found;
        logic               evicted;
        logic [STAMP_W-1:0] oldest;
        access_result_t     r;

        sb = (set_bits_r > SET_BITS_CAP) ? SET_BITS_CAP : int'(set_bits_r);
        nw = (ways_r == 0) ? 1 : ((ways_r > WAY_CAP) ? WAY_CAP : int'(ways_r));
        bb = int'(block_bits_r);
        set_idx = (addr >> bb) & ((64'd1 << sb) - 64'd1);
        tag = (sb + bb >= 64) ? 64'd0 : (addr >> (sb + bb));
        base = int'(set_idx) * WAY_CAP;
        empty_way = -1;
        found = 1'b0;
        evicted = 1'b0;

        // The highest empty way seen before a hit (or overall) wins the fill.
        for (int i = 0; i < nw && !found; i++) begin
            if (!line_valid[base + i])
                empty_way = i;
            else if (line_tag[base + i] == tag) begin
                line_stamp[base + i] = time_now;
                found = 1'b1;
            end
        end

        if (found)
            hits_seen++;
        else begin
            misses_seen++;
            if (empty_way >= 0)
                victim = empty_way;
            else begin
                oldest = line_stamp[base];
                victim = 0;
                for (int i = 1; i < nw; i++) begin
                    if (line_stamp[base + i] < oldest) begin
                        oldest = line_stamp[base + i];
                        victim = i;
                    end
                end
                evicted = 1'b1;
                evictions_seen++;
            end
            line_valid[base + victim] = 1'b1;
            line_tag[base + victim]   = tag;
            line_stamp[base + victim] = time_now;
        end

        r.hit            = found;
        r.miss           = !found;
        r.eviction       = evicted;
        r.last           = is_last;
        r.hit_total      = hits_seen;
        r.miss_total     = misses_seen;
        r.eviction_total = evictions_seen;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < LINE_COUNT; i++) begin
                line_valid[i] = 1'b0;
                line_tag[i]   = '0;
                line_stamp[i] = '0;
            end
            time_now       = '0;
            hits_seen      = '0;
            misses_seen    = '0;
            evictions_seen = '0;
            set_bits_r     = 4'd4;
            ways_r         = 4'd1;
            block_bits_r   = 6'd4;
            pending_results.delete();
            mismatch_count = 0;
            results_due    = 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_SET_BITS:   set_bits_r   = cfg_data[3:0];
                    REG_WAYS:       ways_r       = cfg_data[3:0];
                    REG_BLOCK_BITS: block_bits_r = cfg_data;
                    default: ;
                endcase
            end

            if (in_valid && !in_stall) begin
                case (cmd_t'(cmd))
                    CMD_LOAD, CMD_STORE:
                        pending_results.push_back(predict_access(address, 1'b1));
                    CMD_MODIFY: begin
                        pending_results.push_back(predict_access(address, 1'b0));
                        pending_results.push_back(predict_access(address, 1'b1));
                    end
                    default: ;
                endcase
                time_now++;
            end

            if (out_valid && !out_stall) begin
                got = {hit, miss, eviction, last, hit_total, miss_total, eviction_total};
                if (pending_results.size() == 0)
                    report_mismatch("result arrived with nothing expected");
                else begin
                    want = pending_results.pop_front();
                    if (got !== want)
                        report_mismatch($sformatf(
                            "got h%0b m%0b e%0b l%0b %0d/%0d/%0d want h%0b m%0b e%0b l%0b %0d/%0d/%0d",
                            got.hit, got.miss, got.eviction, got.last,
                            got.hit_total, got.miss_total, got.eviction_total,
                            want.hit, want.miss, want.eviction, want.last,
                            want.hit_total, want.miss_total, want.eviction_total));
                end
            end

            results_due = pending_results.size();
        end
    end

endmodule

// File: sim/tb_set_assoc_lru_cache_sim.sv
module tb_set_assoc_lru_cache_sim;

    import salc_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 30;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 50;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic [1:0]            cmd       = CMD_IFETCH;
    logic [63:0]           address   = '0;
    logic                  out_stall = 1'b0;

    logic                  in_stall;
    logic                  out_valid;
    logic                  hit;
    logic                  miss;
    logic                  eviction;
    logic                  last;
    logic [CNT_W-1:0]      hit_total;
    logic [CNT_W-1:0]      miss_total;
    logic [CNT_W-1:0]      eviction_total;
    int unsigned           mismatch_count;
    int unsigned           results_due;

    int unsigned           cycle_count = 0;
    bit                    calm        = 1'b0;
    bit                    squeeze     = 1'b0;

    // effective settings, kept only to aim addresses at a few sets and tags
    int                    eff_sb      = 4;
    int                    eff_ways    = 1;
    int                    eff_bb      = 4;
    logic [63:0]           tag_pool [10];

    set_assoc_lru_cache_sim dut (.*);

    cache_trace_checker checker_i (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Result side: random stalls, plus one long hold-off when asked.
    initial
    begin
        @(negedge clk);
        forever begin
            if (squeeze) begin
                squeeze = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (!calm && $urandom_range(0, 3) == 0) begin
                out_stall <= 1'b1;
                repeat (1 + gap_len()) @(negedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
    end

    // Enter and leave at a falling edge; valid stays high for a back-to-back request.
    task automatic send_item(input cmd_t c, input logic [63:0] a);
        int unsigned gap;
        gap = gap_len();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        address  <= a;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (results_due != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_settings(input logic [5:0] sb, input logic [5:0] w,
                                  input logic [5:0] bb);
        write_reg(REG_SET_BITS, sb);
        write_reg(REG_WAYS, w);
        write_reg(REG_BLOCK_BITS, bb);
        eff_sb   = (sb[3:0] > 8) ? 8 : int'(sb[3:0]);
        eff_ways = (w[3:0] == 0) ? 1 : ((w[3:0] > 8) ? 8 : int'(w[3:0]));
        eff_bb   = int'(bb);
    endtask

    // Mostly reuse a few tags in a few sets so hits and evictions stay common.
    function automatic logic [63:0] make_address();
        int          tshift;
        int          sets_used;
        logic [63:0] a;
        tshift    = eff_sb + eff_bb;
        sets_used = ((1 << eff_sb) < 4) ? (1 << eff_sb) : 4;
        if ($urandom_range(0, 9) == 0)
            return {$urandom, $urandom};
        a = (tshift >= 64) ? 64'd0 : (tag_pool[$urandom_range(0, eff_ways + 1)] << tshift);
        a |= 64'($urandom_range(0, sets_used - 1)) << eff_bb;
        a |= {$urandom, $urandom} & ((64'd1 << eff_bb) - 64'd1);
        return a;
    endfunction

    function automatic cmd_t pick_cmd();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return CMD_IFETCH;
        if (r < 42)
            return CMD_LOAD;
        if (r < 67)
            return CMD_STORE;
        return CMD_MODIFY;
    endfunction

    initial
    begin
        logic [5:0] sb_list [PHASES];
        logic [5:0] w_list  [PHASES];
        logic [5:0] bb_list [PHASES];

        sb_list = '{6'd2, 6'd0, 6'd8, 6'd3, 6'd47, 6'd1, 6'd5, 6'd8, 6'd4};
        w_list  = '{6'd4, 6'd8, 6'd8, 6'd2, 6'd15, 6'd16, 6'd3, 6'd6, 6'd8};
        bb_list = '{6'd4, 6'd6, 6'd0, 6'd63, 6'd5, 6'd2, 6'd32, 6'd56, 6'd12};

        @(posedge rst_n);
        @(negedge clk);

        // reset settings: 16 sets, direct mapped, 16-byte blocks
        send_item(CMD_IFETCH, 64'd0);
        send_item(CMD_LOAD, 64'd0);
        send_item(CMD_LOAD, 64'h8);
        send_item(CMD_STORE, 64'h100);
        send_item(CMD_MODIFY, 64'h0);
        send_item(CMD_LOAD, '1);
        send_item(CMD_STORE, '1);
        send_item(CMD_IFETCH, '1);
        send_item(CMD_MODIFY, 64'h8000_0000_0000_0000);

        // oversized set_bits and ways; the tag shift reaches 64, so every tag is zero
        settle();
        apply_settings(6'd47, 6'd15, 6'd56);
        send_item(CMD_LOAD, 64'hFF00_0000_0000_0000);
        send_item(CMD_LOAD, 64'hFF12_3456_789A_BCDE);
        send_item(CMD_STORE, 64'h0100_0000_0000_0000);

        // ways written as zero, widest block offset; old lines are read as they stand
        settle();
        apply_settings(6'd0, 6'd16, 6'd63);
        send_item(CMD_LOAD, 64'd0);
        send_item(CMD_LOAD, 64'h8000_0000_0000_0000);
        send_item(CMD_MODIFY, 64'h8000_0000_0000_0000);

        // one fully associative set: fill, refresh one line, then evict the oldest two
        settle();
        apply_settings(6'd0, 6'd8, 6'd0);
        for (int i = 1; i <= 7; i++)
            send_item(CMD_LOAD, 64'(i) << 4);
        send_item(CMD_LOAD, 64'h10);
        send_item(CMD_STORE, 64'h90);
        send_item(CMD_STORE, 64'hA0);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            apply_settings(sb_list[p], w_list[p], bb_list[p]);
            foreach (tag_pool[k])
                tag_pool[k] = {$urandom, $urandom};
            calm = (p == 0 || p == 1 || p == 5);
            // hold the result side off while requests keep coming
            if (p == 1)
                squeeze = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(pick_cmd(), make_address());
        end

        settle();
        if (mismatch_count == 0 && results_due == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: set_assoc_lru_cache_sim.f
hdl/salc_pkg.sv
hdl/salc_front.sv
hdl/salc_queue.sv
hdl/salc_back.sv
hdl/set_assoc_lru_cache_sim.sv
sim/cache_trace_checker.sv
sim/tb_set_assoc_lru_cache_sim.sv
